### src/assert_macros.svh
// Assertion macros used by the top level RTL file of the slot pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define FSP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold at every clock edge, also during reset.
`define FSP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) (cond)) else $error(msg);

`endif

### src/fsp_pkg.sv
// Types and constants of the frame slot pool.
`default_nettype none

package fsp_pkg;

   localparam int RETRY_W = 4;
   localparam logic [RETRY_W-1:0] RETRY_MAX = 4'd15;
   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 4'd3;

   // command codes
   localparam logic [1:0] CMD_ALLOCATE = 2'd0;
   localparam logic [1:0] CMD_GET      = 2'd1;
   localparam logic [1:0] CMD_FREE     = 2'd2;

   // one slot entry of the memory
   typedef struct packed {
      logic               busy;
      logic [RETRY_W-1:0] retries;
   } entry_type;

   localparam entry_type ENTRY_FREE = '{busy: 1'b0, retries: 4'd0};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### src/fsp_slot_mem.sv
// Slot entry memory: one write port, one read port, registered read data.
`default_nettype none

module fsp_slot_mem #(
   parameter int ADDR_W = 3
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [ADDR_W-1:0]        wr_addr,
   input  wire  fsp_pkg::entry_type wr_data,
   input  wire  [ADDR_W-1:0]        rd_addr,
   output fsp_pkg::entry_type       rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   fsp_pkg::entry_type mem_ff [DEPTH];
   fsp_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/frame_slot_pool_with_retry_aging.sv
// Top level of the frame slot pool with retry aging.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  req     | in        | req_tvalid / req_tready | tuser command, pool; tdata slot
//  rsp     | out       | rsp_tvalid / rsp_tready | tuser found; tdata slot, retries
//  csr     | in        | csr_valid / csr_ready   | csr_wdata retry limit
//
// One request at a time. Allocate and get walk the pool's slots through the
// registered memory read port, a read and an eval state per slot, then the
// finish state; allocate stops at the first free slot. Free goes straight to finish.
// After reset a clearing pass writes all 2**(SLOT_W+1) entries of both pools
// before req_tready rises.
// The finish cycle waits while an earlier response still sits in rsp.
`default_nettype none

module frame_slot_pool_with_retry_aging #(
   parameter int SLOTS_PER_POOL = 4
) (
   input  wire        clock,
   input  wire        reset,
   // requests
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [1:0] slot_to_free, [7:2] zero
   input  wire  [2:0] req_tuser,   // [1:0] command, [2] queue_select
   // responses
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [1:0] slot_index, [5:2] retry_count, [7:6] zero
   output logic [0:0] rsp_tuser,   // [0] found
   // retry limit register
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [3:0] csr_wdata
);

   localparam int SLOT_W    = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
   localparam int ADDR_W    = SLOT_W + 1;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_POOL - 1);
   localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MEM_DEPTH - 1);

   fsp_pkg::state_type state_ff, state_in;

   logic [1:0]                  cmd_ff, cmd_in;
   logic                        pool_ff, pool_in;
   logic [1:0]                  free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0]           idx_ff, idx_in;
   logic                        have_ff, have_in;
   logic [SLOT_W-1:0]           best_ff, best_in;
   logic [fsp_pkg::RETRY_W-1:0] best_r_ff, best_r_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [1:0]                  rsp_slot_ff, rsp_slot_in;
   logic [fsp_pkg::RETRY_W-1:0] rsp_retry_ff, rsp_retry_in;
   logic [fsp_pkg::RETRY_W-1:0] retry_limit_ff;

   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   fsp_pkg::entry_type          mem_wr_data;
   logic [ADDR_W-1:0]           mem_rd_addr;
   fsp_pkg::entry_type          mem_rd_data;

   logic                        req_accept;
   logic                        out_free;
   logic                        aged;
   logic [SLOT_W+1:0]           free_slot_wide;
   logic [SLOT_W+1:0]           best_wide;
   logic                        free_ok;
   logic [fsp_pkg::RETRY_W-1:0] best_r_inc;

   fsp_slot_mem #(
      .ADDR_W (ADDR_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // handshake helpers
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // slot index helpers
   assign free_slot_wide = (SLOT_W + 2)'(free_slot_ff);
   assign free_ok        = 32'(free_slot_ff) < SLOTS_PER_POOL;
   assign best_wide      = (SLOT_W + 2)'(best_ff);
   assign best_r_inc     = (best_r_ff == fsp_pkg::RETRY_MAX) ? fsp_pkg::RETRY_MAX
                                                             : best_r_ff + 4'd1;
   assign aged           = mem_rd_data.busy && (mem_rd_data.retries >= retry_limit_ff);

   // state register and request context
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      pool_ff      <= pool_in;
      free_slot_ff <= free_slot_in;
      idx_ff       <= idx_in;
      have_ff      <= have_in;
      best_ff      <= best_in;
      best_r_ff    <= best_r_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_retry_ff <= rsp_retry_in;
   end

   // retry limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= fsp_pkg::RETRY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         retry_limit_ff <= csr_wdata;
      end
   end

   // next state, memory accesses and response load
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pool_in      = pool_ff;
      free_slot_in = free_slot_ff;
      idx_in       = idx_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_r_in    = best_r_ff;
      clr_in       = clr_ff;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_retry_in = rsp_retry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {pool_ff, idx_ff};
      mem_wr_data  = fsp_pkg::ENTRY_FREE;
      mem_rd_addr  = {pool_ff, idx_ff};

      case (state_ff)
         fsp_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = fsp_pkg::ST_IDLE;
            end
         end
         fsp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               cmd_in       = req_tuser[1:0];
               pool_in      = req_tuser[2];
               free_slot_in = req_tdata[1:0];
               idx_in       = '0;
               have_in      = 1'b0;
               best_in      = '0;
               best_r_in    = '0;
               if (req_tuser[1:0] inside {fsp_pkg::CMD_ALLOCATE, fsp_pkg::CMD_GET}) begin
                  state_in = fsp_pkg::ST_READ;
               end else begin
                  state_in = fsp_pkg::ST_FINISH;
               end
            end
         end
         fsp_pkg::ST_READ: begin
            state_in = fsp_pkg::ST_EVAL;
         end
         fsp_pkg::ST_EVAL: begin
            state_in = (idx_ff == SLOT_LAST) ? fsp_pkg::ST_FINISH : fsp_pkg::ST_READ;
            idx_in   = idx_ff + 1'b1;
            if (cmd_ff == fsp_pkg::CMD_ALLOCATE) begin
               // first free slot wins
               if (!mem_rd_data.busy) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = '{busy: 1'b1, retries: '0};
                  have_in     = 1'b1;
                  best_in     = idx_ff;
                  best_r_in   = '0;
                  state_in    = fsp_pkg::ST_FINISH;
               end
            end else begin
               // age out, then keep the lowest retry count seen so far
               if (aged) begin
                  mem_wr_en = 1'b1;
               end else if (mem_rd_data.busy &&
                            (!have_ff || (mem_rd_data.retries < best_r_ff))) begin
                  have_in   = 1'b1;
                  best_in   = idx_ff;
                  best_r_in = mem_rd_data.retries;
               end
            end
         end
         fsp_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = have_ff;
               rsp_slot_in  = have_ff ? best_wide[1:0] : 2'd0;
               rsp_retry_in = '0;
               state_in     = fsp_pkg::ST_IDLE;
               if (cmd_ff == fsp_pkg::CMD_GET && have_ff) begin
                  mem_wr_en    = 1'b1;
                  mem_wr_addr  = {pool_ff, best_ff};
                  mem_wr_data  = '{busy: 1'b1, retries: best_r_inc};
                  rsp_retry_in = best_r_inc;
               end else if (cmd_ff == fsp_pkg::CMD_FREE && free_ok) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = {pool_ff, free_slot_wide[SLOT_W-1:0]};
               end
            end
         end
         default: begin
            state_in = fsp_pkg::ST_IDLE;
         end
      endcase
   end

   // response port
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_found_ff;
   assign rsp_tdata    = {2'b00, rsp_retry_ff, rsp_slot_ff};

`include "assert_macros.svh"

   `FSP_ASSERT_IMP(a_no_req_in_clear, state_ff == fsp_pkg::ST_CLEAR, !req_tready, "request taken during clearing pass")
   `FSP_ASSERT_IMP(a_miss_all_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 8'd0, "miss response carries nonzero data")
   `FSP_ASSERT_IMP(a_retry_in_limit, rsp_tvalid && rsp_tuser[0], rsp_retry_ff <= retry_limit_ff, "returned retry count beyond limit")
   `FSP_ASSERT_IMP(a_write_states, mem_wr_en, state_ff == fsp_pkg::ST_CLEAR || state_ff == fsp_pkg::ST_EVAL || state_ff == fsp_pkg::ST_FINISH, "memory write outside clear, eval or finish")

endmodule

`default_nettype wire
